/* sv/nrp_pkg.sv */
// Shared types and constants for the no-repeat random picker.
`default_nettype none

package nrp_pkg;

  localparam int unsigned RandW  = 31;
  localparam int unsigned CountW = 6;
  localparam int unsigned SlotW  = 5;

  typedef enum logic {
    OpSelect = 1'b0,
    OpReset  = 1'b1
  } nrp_op_e;

  typedef struct packed {
    logic              operation;
    logic [RandW-1:0]  random_value;
  } nrp_in_t;

  typedef struct packed {
    logic              picked;
    logic [SlotW-1:0]  slot_index;
    logic              restarted;
    logic [CountW-1:0] remaining;
  } nrp_out_t;

  // Search wave handed from one slot cell to the next.
  typedef struct packed {
    logic              valid;
    logic [CountW-1:0] count;
  } nrp_wave_t;

endpackage

`default_nettype wire

/* sv/nrp_cell.sv */
// One slot cell: holds the slot's used flag and forwards the search wave.
`default_nettype none

module nrp_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  nrp_pkg::nrp_wave_t wave_i,
  output nrp_pkg::nrp_wave_t wave_o,
  output logic               used_o,
  output logic               hit_o
);

  logic                       used_q;
  logic                       wave_valid_q;
  logic [nrp_pkg::CountW-1:0] wave_count_q;
  logic                       free;

  // The wave stops at the free slot whose count has run down to zero;
  // otherwise it moves on, counting down once per free slot passed.
  always_comb begin
    free         = !used_q;
    hit_o        = wave_valid_q && free && (wave_count_q == '0);
    wave_o.valid = wave_valid_q && !hit_o;
    wave_o.count = free ? (wave_count_q - nrp_pkg::CountW'(1)) : wave_count_q;
  end

  assign used_o = used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= 1'b0;
      wave_valid_q <= 1'b0;
    end else begin
      wave_valid_q <= wave_i.valid;
      if (clear_i) begin
        used_q <= 1'b0;
      end else if (hit_o) begin
        used_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wave_count_q <= wave_i.count;
  end

endmodule

`default_nettype wire

/* sv/nrp_divider.sv */
// Bit-serial restoring remainder of the random word by the free slot count.
`default_nettype none

module nrp_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [nrp_pkg::RandW-1:0]  dividend_i,
  input  logic [nrp_pkg::CountW-1:0] divisor_i,
  output logic                       done_o,
  output logic [nrp_pkg::CountW-1:0] rem_o
);

  localparam int unsigned StepW = $clog2(nrp_pkg::RandW);
  localparam logic [StepW-1:0] LastStep = StepW'(nrp_pkg::RandW - 1);

  logic [nrp_pkg::RandW-1:0]  dividend_q;
  logic [nrp_pkg::CountW-1:0] divisor_q;
  logic [nrp_pkg::CountW-1:0] rem_q, rem_d;
  logic [StepW-1:0]           step_q;
  logic                       busy_q;
  logic                       done_q;
  logic [nrp_pkg::CountW:0]   trial;

  // One quotient bit per cycle; the remainder always stays below the divisor.
  always_comb begin
    trial = {rem_q, dividend_q[nrp_pkg::RandW-1]};
    if (trial >= {1'b0, divisor_q}) begin
      rem_d = nrp_pkg::CountW'(trial - {1'b0, divisor_q});
    end else begin
      rem_d = trial[nrp_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dividend_q <= dividend_i;
      divisor_q  <= divisor_i;
      rem_q      <= '0;
    end else if (busy_q) begin
      dividend_q <= {dividend_q[nrp_pkg::RandW-2:0], 1'b0};
      rem_q      <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* sv/no_repeat_random_picker_core.sv */
// Top level of the no-repeat random picker: sequencer, slot cell chain, output register.
//
//   Channel   Direction  Handshake                  Payload
//   in        to core    in_valid_i / in_stall_o    in_data_i  (nrp_in_t)
//   out       from core  out_valid_o / out_stall_i  out_data_o (nrp_out_t)
//   cfg       to core    cfg_we_i                   cfg_wdata_i (pool_size)
//
// A select transaction first runs the bit-serial remainder, then the search wave walks
// the slot cell chain one cell per cycle until the chosen slot stops it. A cycle reset,
// or a select on an empty pool, skips both. Each result waits in the done state until it
// is loaded into the output register; the input stalls from acceptance until that load,
// and a result stalled in the output register holds back the next one. Reset clears the
// pool size, the used flags and the used count at once; there is no clearing pass.
`default_nettype none

module no_repeat_random_picker_core #(
  parameter int unsigned MAX_SLOTS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  nrp_pkg::nrp_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output nrp_pkg::nrp_out_t          out_data_o,
  input  logic                       cfg_we_i,
  input  logic [nrp_pkg::CountW-1:0] cfg_wdata_i
);

  localparam int unsigned PosW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [nrp_pkg::CountW:0] MaxSlotsW = (nrp_pkg::CountW + 1)'(MAX_SLOTS);

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StScan = 4'b0100,
    StDone = 4'b1000
  } nrp_state_e;

  nrp_state_e                  state_q, state_d;
  logic [nrp_pkg::CountW-1:0]  pool_size_q;
  logic [nrp_pkg::CountW-1:0]  used_total_q, used_total_d;
  logic [nrp_pkg::CountW-1:0]  eff_size;
  logic [nrp_pkg::CountW-1:0]  used_base;
  logic [nrp_pkg::CountW-1:0]  used_next;
  logic [PosW-1:0]             pos_q, pos_d;
  logic                        restart_q, restart_d;
  nrp_pkg::nrp_out_t           res_q, res_d;
  logic                        res_load;
  nrp_pkg::nrp_out_t           out_data_q;
  logic                        out_valid_q;
  logic                        accept;
  logic                        is_reset_op;
  logic                        need_restart;
  logic                        clear_cycle;
  logic                        div_start;
  logic                        div_done;
  logic [nrp_pkg::CountW-1:0]  div_rem;
  logic                        out_free;

  nrp_pkg::nrp_wave_t          wave_link [MAX_SLOTS+1];
  logic [MAX_SLOTS-1:0]        hit_vec;
  logic [MAX_SLOTS-1:0]        used_vec;
  logic                        hit_any;

  // A pool size above the number of cells is clipped to the cell count.
  assign eff_size = ({1'b0, pool_size_q} > MaxSlotsW) ? MaxSlotsW[nrp_pkg::CountW-1:0]
                                                      : pool_size_q;

  assign in_stall_o   = (state_q != StIdle);
  assign accept       = in_valid_i && !in_stall_o;
  assign is_reset_op  = (in_data_i.operation == nrp_pkg::OpReset);
  // When every slot is used, a select starts a new cycle before picking.
  assign need_restart = (used_total_q >= eff_size);
  assign used_base    = need_restart ? '0 : used_total_q;
  assign used_next    = used_total_q + nrp_pkg::CountW'(1);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign hit_any      = |hit_vec;

  assign clear_cycle = cfg_we_i ||
                       (accept && (is_reset_op || ((eff_size != '0) && need_restart)));

  assign div_start = accept && !is_reset_op && (eff_size != '0);

  // The remainder selects the free slot by rank; the wave enters cell 0 once it is ready.
  assign wave_link[0] = '{valid: (state_q == StDiv) && div_done, count: div_rem};

  always_comb begin
    state_d      = state_q;
    used_total_d = used_total_q;
    pos_d        = pos_q;
    restart_d    = restart_q;
    res_d        = res_q;
    res_load     = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          res_load = 1'b1;
          res_d    = '0;
          if (is_reset_op) begin
            used_total_d    = '0;
            res_d.remaining = eff_size;
            state_d         = StDone;
          end else if (eff_size == '0) begin
            state_d = StDone;
          end else begin
            used_total_d = used_base;
            restart_d    = need_restart;
            state_d      = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          pos_d   = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        pos_d = pos_q + PosW'(1);
        if (hit_any) begin
          used_total_d     = used_next;
          res_load         = 1'b1;
          res_d.picked     = 1'b1;
          res_d.slot_index = nrp_pkg::SlotW'(pos_q);
          res_d.restarted  = restart_q;
          res_d.remaining  = eff_size - used_next;
          state_d          = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (cfg_we_i) begin
      used_total_d = '0;
    end
  end

  nrp_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_data_i.random_value),
    .divisor_i  (eff_size - used_base),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Chain of slot cells; the wave moves one cell further each cycle, so the
  // cell holding the wave is always the one at index pos_q.
  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    nrp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear_cycle),
      .wave_i  (wave_link[g]),
      .wave_o  (wave_link[g+1]),
      .used_o  (used_vec[g]),
      .hit_o   (hit_vec[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      pool_size_q  <= '0;
      used_total_q <= '0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_total_q <= used_total_d;
      pos_q        <= pos_d;
      if (cfg_we_i) begin
        pool_size_q <= cfg_wdata_i;
      end
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    restart_q <= restart_d;
    if (res_load) begin
      res_q <= res_d;
    end
    if ((state_q == StDone) && out_free) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // At most one cell can stop the wave.
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one slot cell hit");

  // The rank is below the free count, so the wave never runs off the chain.
  a_wave_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wave_link[MAX_SLOTS].valid)
    else $error("search wave left the last slot cell");

  // The used count tracks the used flags held in the cells.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_vec) == int'(used_total_q))
    else $error("used count disagrees with used flags");

  // The used count never exceeds the pool size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_total_q <= eff_size)
    else $error("used count above pool size");

  // Hits only come while the sequencer is searching.
  a_hit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_any |-> (state_q == StScan))
    else $error("slot hit outside of the search");

endmodule

`default_nettype wire

/* dv/no_repeat_random_picker_core_test.sv */
// Self-checking testbench for the no-repeat random picker core.
module no_repeat_random_picker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlotCap    = 32;      // MAX_SLOTS of the instance below
  localparam int unsigned ClkPeriod  = 8;
  localparam int unsigned ResetLen   = 12;
  localparam int unsigned SegItems   = 110;     // random transactions per pool setting
  localparam int unsigned SegCount   = 15;      // five settings per idling phase
  localparam int unsigned SettleLen  = 4;       // quiet cycles before a pool size write
  localparam int unsigned DrainLen   = 80;      // quiet cycles after the last expected result
  localparam int unsigned CycleLimit = 1000000;

  // Scoreboard: keeps its own copy of the taken flags, the taken total and the
  // pool size, and turns every accepted request into the pick it should cause.
  class nrp_scoreboard;
    bit [SlotCap-1:0]          taken_flags;
    bit [nrp_pkg::CountW-1:0]  taken_total;
    bit [nrp_pkg::CountW-1:0]  pool_size;
    nrp_pkg::nrp_out_t         expected_picks[$];
    int unsigned               errors;

    function void clear_cycle();
      taken_flags = '0;
      taken_total = '0;
    endfunction

    // A pool size write also starts a fresh usage cycle.
    function void load_pool_size(bit [nrp_pkg::CountW-1:0] size);
      pool_size = size;
      clear_cycle();
    endfunction

    function int unsigned pending();
      return expected_picks.size();
    endfunction

    function void predict_pick(nrp_pkg::nrp_in_t req);
      nrp_pkg::nrp_out_t pick;
      int unsigned       slots;
      int unsigned       free_cnt;
      int unsigned       target;
      int unsigned       seen;
      bit                found;
      pick  = '0;
      // Sizes above the slot count behave as a full pool.
      slots = (pool_size > SlotCap) ? SlotCap : pool_size;
      if (req.operation == nrp_pkg::OpReset) begin
        clear_cycle();
      end else if (slots != 0) begin
        // Every slot handed out: start over before choosing.
        if (taken_total >= slots) begin
          clear_cycle();
          pick.restarted = 1'b1;
        end
        free_cnt = 0;
        for (int unsigned i = 0; i < slots; i++) begin
          if (!taken_flags[i]) free_cnt++;
        end
        if (free_cnt != 0) begin
          target = req.random_value % free_cnt;
          seen   = 0;
          found  = 1'b0;
          // Walk the free slots in ascending order up to the chosen position.
          for (int unsigned i = 0; i < slots; i++) begin
            if (!found && !taken_flags[i]) begin
              if (seen == target) begin
                found           = 1'b1;
                pick.slot_index = i[nrp_pkg::SlotW-1:0];
                taken_flags[i]  = 1'b1;
              end
              seen++;
            end
          end
          taken_total = taken_total + 1'b1;
          pick.picked = 1'b1;
        end
      end
      if (slots != 0 && slots >= taken_total) begin
        pick.remaining = nrp_pkg::CountW'(slots - taken_total);
      end
      expected_picks.push_back(pick);
    endfunction

    function void check_pick(nrp_pkg::nrp_out_t got);
      nrp_pkg::nrp_out_t want;
      if (expected_picks.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        errors++;
        return;
      end
      want = expected_picks.pop_front();
      if (got.picked !== want.picked) begin
        $error("picked: expected %0d, actual %0d", want.picked, got.picked);
        errors++;
      end
      if (got.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
        errors++;
      end
      if (got.restarted !== want.restarted) begin
        $error("restarted: expected %0d, actual %0d", want.restarted, got.restarted);
        errors++;
      end
      if (got.remaining !== want.remaining) begin
        $error("remaining: expected %0d, actual %0d", want.remaining, got.remaining);
        errors++;
      end
    endfunction
  endclass

  // Every input of the core starts at a known value; reset is held from time zero.
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  nrp_pkg::nrp_in_t           in_data_i   = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  nrp_pkg::nrp_out_t          out_data_o;
  logic                       cfg_we_i    = 1'b0;
  logic [nrp_pkg::CountW-1:0] cfg_wdata_i = '0;

  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   cycle_count   = 0;
  nrp_scoreboard sb            = new();

  no_repeat_random_picker_core #(
    .MAX_SLOTS(SlotCap)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side. Signals are read right after the edge, so they hold the values
  // the core saw at that edge; a result counts when valid was high and our stall
  // low. The stall for the next cycle is then drawn from the current idling rate.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_pick(out_data_o);
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic nrp_pkg::nrp_in_t make_request(nrp_pkg::nrp_op_e op,
                                                    logic [nrp_pkg::RandW-1:0] rnd);
    nrp_pkg::nrp_in_t req;
    req.operation    = op;
    req.random_value = rnd;
    return req;
  endfunction

  // Offers one transaction and returns at the edge where the core takes it.
  // The valid line is either lowered for a gap or kept high for the new
  // payload, never both in one step, so back-to-back transactions stay clean.
  task automatic send_request(nrp_pkg::nrp_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.predict_pick(req);
  endtask

  // The pool size is only changed with the core idle: nothing offered, every
  // expected result drained, and SettleLen quiet cycles on top.
  task automatic write_pool_size(logic [nrp_pkg::CountW-1:0] size);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleLen) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    sb.load_pool_size(size);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [nrp_pkg::CountW-1:0] size;
    logic [nrp_pkg::RandW-1:0]  rnd;
    nrp_pkg::nrp_op_e           op;

    repeat (ResetLen) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with the first idling mix.
    send_idle_pct = 37;
    recv_idle_pct = 73;

    // The pool is empty out of reset: a select picks nothing, a cycle reset
    // reports zero remaining.
    send_request(make_request(nrp_pkg::OpSelect, '0));
    send_request(make_request(nrp_pkg::OpReset, '1));

    // A single slot: the second select has to restart the cycle.
    write_pool_size(6'd1);
    send_request(make_request(nrp_pkg::OpSelect, '1));
    send_request(make_request(nrp_pkg::OpSelect, '0));
    send_request(make_request(nrp_pkg::OpReset, '0));

    // Full pool with the extremes of the random word.
    write_pool_size(6'd32);
    send_request(make_request(nrp_pkg::OpSelect, '0));
    send_request(make_request(nrp_pkg::OpSelect, '1));
    send_request(make_request(nrp_pkg::OpSelect, 31'd30));
    send_request(make_request(nrp_pkg::OpReset, 31'h2AAA_AAAA));
    send_request(make_request(nrp_pkg::OpSelect, 31'h5555_5555));

    // Sizes past the slot count are clipped to a full pool.
    write_pool_size(6'd63);
    send_request(make_request(nrp_pkg::OpSelect, '1));
    send_request(make_request(nrp_pkg::OpSelect, 31'd30));
    write_pool_size(6'd33);
    send_request(make_request(nrp_pkg::OpSelect, 31'd31));

    // Two slots: use both, restart on the third select, then clear the cycle.
    write_pool_size(6'd2);
    send_request(make_request(nrp_pkg::OpSelect, 31'd1));
    send_request(make_request(nrp_pkg::OpSelect, 31'd7));
    send_request(make_request(nrp_pkg::OpSelect, 31'd2));
    send_request(make_request(nrp_pkg::OpReset, '1));

    // Random part: one pool size per segment, five segments per idling mix.
    for (int unsigned seg = 0; seg < SegCount; seg++) begin
      case (seg / 5)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // Mostly real pools, so that cycles fill up and restart; an empty or
      // oversized pool now and then.
      case ($urandom_range(9))
        0:       size = 6'd0;
        1:       size = 6'd1;
        2:       size = 6'd32;
        3:       size = nrp_pkg::CountW'($urandom_range(63, 33));
        4:       size = 6'd2;
        default: size = nrp_pkg::CountW'($urandom_range(32, 1));
      endcase
      write_pool_size(size);
      for (int unsigned n = 0; n < SegItems; n++) begin
        case ($urandom_range(19))
          0:       rnd = '1 - nrp_pkg::RandW'($urandom_range(3));
          1, 2:    rnd = nrp_pkg::RandW'($urandom_range(63));
          default: rnd = nrp_pkg::RandW'($urandom());
        endcase
        op = ($urandom_range(24) == 0) ? nrp_pkg::OpReset : nrp_pkg::OpSelect;
        send_request(make_request(op, rnd));
      end
    end

    // Drain: every expected result in, then a quiet stretch for stray output.
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainLen) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* no_repeat_random_picker_core.f */
sv/nrp_pkg.sv
sv/nrp_cell.sv
sv/nrp_divider.sv
sv/no_repeat_random_picker_core.sv
dv/no_repeat_random_picker_core_test.sv
